>>> rtl/hpid_pkg.sv
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types and constants of the heading PID turn controller: register
// indexes, reset values, settle and stall limits, and the structs that carry
// configuration, controller state, input requests and results.
// ----------------------------------------------------------------------------
package hpid_pkg;

    // Exit limits, in ticks.
    localparam logic [6:0] STALL_LIMIT  = 7'd60;
    localparam logic [2:0] SETTLE_LIMIT = 3'd5;

    // Saturation points of the tick counters.
    localparam logic [6:0] STALL_MAX  = 7'd127;
    localparam logic [2:0] SETTLE_MAX = 3'd7;

    // Integration zone and settle band, in sixteenths of a degree.
    localparam logic [13:0] INT_ZONE    = 14'd160;
    localparam logic [13:0] SETTLE_BAND = 14'd32;

    // Saturation bounds of the integral sum.
    localparam logic signed [29:0] ISUM_MAX = 30'sd8388607;
    localparam logic signed [29:0] ISUM_MIN = -30'sd8388608;

    // Register reset values.
    localparam logic signed [9:0] TARGET_RESET  = 10'sd0;
    localparam logic [6:0]        LIMIT_RESET   = 7'd127;
    localparam logic [11:0]       GAIN_P_RESET  = 12'd614;
    localparam logic [11:0]       GAIN_I_RESET  = 12'd205;
    localparam logic [11:0]       GAIN_D_RESET  = 12'd115;

    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 3;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_ANGLE  = 3'd0,
        REG_VOLTAGE_LIMIT = 3'd1,
        REG_GAIN_P        = 3'd2,
        REG_GAIN_I        = 3'd3,
        REG_GAIN_D        = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [9:0] target_angle;
        logic [6:0]        voltage_limit;
        logic [11:0]       gain_p;
        logic [11:0]       gain_i;
        logic [11:0]       gain_d;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] integral_sum;
        logic signed [14:0] previous_error;
        logic [9:0]         previous_whole_error;
        logic [6:0]         stall_ticks;
        logic [2:0]         settle_ticks;
        logic               done_flag;
    } state_t;

    typedef struct packed {
        logic [12:0] heading;
        logic        restart;
    } item_t;

    typedef struct packed {
        logic signed [7:0] drive_level;
        logic              finished;
        logic [13:0]       error_magnitude;
    } result_t;

endpackage

>>> rtl/hpid_if.sv
// ----------------------------------------------------------------------------
// hpid_if
// Valid/ready channels of the heading PID turn controller: one carries
// heading requests in, the other carries drive results out.
// ----------------------------------------------------------------------------
interface hpid_in_if;
    logic        valid;
    logic        ready;
    logic [12:0] heading;
    logic        restart;

    modport source (output valid, output heading, output restart, input ready);
    modport sink   (input valid, input heading, input restart, output ready);
endinterface

interface hpid_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] drive_level;
    logic              finished;
    logic [13:0]       error_magnitude;

    modport source (output valid, output drive_level, output finished,
                    output error_magnitude, input ready);
    modport sink   (input valid, input drive_level, input finished,
                    input error_magnitude, output ready);
endinterface

>>> rtl/hpid_core.sv
// ----------------------------------------------------------------------------
// hpid_core
// One controller tick: heading error, P, I and D terms, drive clamp, and the
// settle and stall check. Returns the next controller state and the result.
// ----------------------------------------------------------------------------
module hpid_core
    import hpid_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    state_t             cur;
    logic signed [14:0] err;
    logic [14:0]        err_neg;
    logic [13:0]        mag;
    logic [14:0]        prev_neg;
    logic [13:0]        prev_mag;
    logic signed [12:0] gp;
    logic signed [12:0] gi;
    logic signed [12:0] gd;
    logic signed [27:0] p_prod;
    logic signed [27:0] p_adj;
    logic signed [15:0] p_val;
    logic signed [15:0] diff;
    logic signed [28:0] d_prod;
    logic signed [28:0] d_adj;
    logic signed [16:0] d_val;
    logic signed [24:0] i_base;
    logic signed [37:0] i_prod;
    logic signed [37:0] i_adj;
    logic signed [29:0] i_q;
    logic signed [23:0] i_new;
    logic signed [17:0] pd;
    logic signed [25:0] acc;
    logic signed [25:0] acc_adj;
    logic signed [21:0] drv_q;
    logic signed [21:0] lim;
    logic signed [21:0] drv_c;
    logic [9:0]         whole;
    logic               same;
    logic               band;
    logic [2:0]         settle_n;
    logic [6:0]         stall_n;
    logic               leave;

    always_comb
    begin
        // A restart clears the history before this tick is worked.
        cur = item.restart ? '0 : st;

        // Error in sixteenths of a degree and its magnitude.
        err     = $signed({cfg.target_angle[9], cfg.target_angle, 4'b0000})
                - $signed({2'b00, item.heading});
        err_neg = -err;
        mag     = err[14] ? err_neg[13:0] : err[13:0];
        prev_neg = -cur.previous_error;
        prev_mag = cur.previous_error[14] ? prev_neg[13:0] : cur.previous_error[13:0];

        gp = $signed({1'b0, cfg.gain_p});
        gi = $signed({1'b0, cfg.gain_i});
        gd = $signed({1'b0, cfg.gain_d});

        // Proportional term, divided by 4096 toward zero.
        p_prod = $signed({{13{err[14]}}, err}) * $signed({{15{1'b0}}, gp});
        p_adj  = p_prod + (p_prod[27] ? 28'sd4095 : 28'sd0);
        p_val  = p_adj[27:12];

        // Derivative term, divided by 4096 toward zero.
        diff   = $signed({err[14], err}) - $signed({cur.previous_error[14],
                                                    cur.previous_error});
        d_prod = $signed({{13{diff[15]}}, diff}) * $signed({{16{1'b0}}, gd});
        d_adj  = d_prod + (d_prod[28] ? 29'sd4095 : 29'sd0);
        d_val  = d_adj[28:12];

        // Integral term, divided by 256 toward zero and saturated; cleared outside the integration zone.
        i_base = $signed({cur.integral_sum[23], cur.integral_sum})
               + $signed({{10{err[14]}}, err});
        i_prod = $signed({{13{i_base[24]}}, i_base}) * $signed({{25{1'b0}}, gi});
        i_adj  = i_prod + (i_prod[37] ? 38'sd255 : 38'sd0);
        i_q    = i_adj[37:8];
        if (mag >= INT_ZONE)
        begin
            i_new = '0;
        end
        else if (i_q > ISUM_MAX)
        begin
            i_new = ISUM_MAX[23:0];
        end
        else if (i_q < ISUM_MIN)
        begin
            i_new = ISUM_MIN[23:0];
        end
        else
        begin
            i_new = i_q[23:0];
        end

        // Drive level, divided by 16 toward zero and clamped.
        pd      = $signed({{2{p_val[15]}}, p_val}) + $signed({d_val[16], d_val});
        acc     = $signed({{4{pd[17]}}, pd, 4'b0000})
                + $signed({{2{i_new[23]}}, i_new});
        acc_adj = acc + (acc[25] ? 26'sd15 : 26'sd0);
        drv_q   = acc_adj[25:4];
        lim     = $signed({15'b0, cfg.voltage_limit});
        if (drv_q > lim)
        begin
            drv_c = lim;
        end
        else if (drv_q < -lim)
        begin
            drv_c = -lim;
        end
        else
        begin
            drv_c = drv_q;
        end

        // Settle and stall counters on the whole-degree error.
        whole = mag[13:4];
        same  = (whole == cur.previous_whole_error);
        band  = (mag <= SETTLE_BAND) && (prev_mag <= SETTLE_BAND);
        if (same)
        begin
            settle_n = (band && cur.settle_ticks < SETTLE_MAX)
                     ? cur.settle_ticks + 3'd1 : cur.settle_ticks;
            stall_n  = (cur.stall_ticks < STALL_MAX)
                     ? cur.stall_ticks + 7'd1 : cur.stall_ticks;
        end
        else
        begin
            settle_n = '0;
            stall_n  = '0;
        end
        leave = (settle_n >= SETTLE_LIMIT) || (stall_n >= STALL_LIMIT);

        // Next state and result; a finished controller stays frozen.
        res.error_magnitude = mag;
        if (cur.done_flag)
        begin
            st_next         = cur;
            res.drive_level = '0;
            res.finished    = 1'b1;
        end
        else
        begin
            st_next.integral_sum = i_new;
            st_next.settle_ticks = settle_n;
            st_next.stall_ticks  = stall_n;
            st_next.done_flag    = leave;
            if (leave)
            begin
                st_next.previous_error       = cur.previous_error;
                st_next.previous_whole_error = cur.previous_whole_error;
                res.drive_level              = '0;
            end
            else
            begin
                st_next.previous_error       = err;
                st_next.previous_whole_error = whole;
                res.drive_level              = drv_c[7:0];
            end
            res.finished = leave;
        end
    end

endmodule

>>> rtl/heading_pid_turn_controller_top.sv
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_top
// Heading PID turn controller with settle and stall exit detection.
// ----------------------------------------------------------------------------
// The controller takes one heading request per clock cycle unless the result
// side stalls, and returns one drive result for each, in order. A request
// is captured into an input register, worked in a single pass through the
// PID and settle logic, and written to the result register when that
// register is free or drains. The rate of one request per cycle is set by
// that single pass, which updates the integral sum, the error history and
// the tick counters in the same cycle. The result register parts the two
// sides: a new request is taken while a finished result still waits. The
// user must write registers through the configuration port only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_top
    import hpid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    hpid_in_if.sink                in_ch,
    hpid_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    result_t res_next;
    result_t res_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    advance;

    // The held request moves on when the result register is free or drains.
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    hpid_core u_core (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_angle  <= TARGET_RESET;
            cfg_reg.voltage_limit <= LIMIT_RESET;
            cfg_reg.gain_p        <= GAIN_P_RESET;
            cfg_reg.gain_i        <= GAIN_I_RESET;
            cfg_reg.gain_d        <= GAIN_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_ANGLE:  cfg_reg.target_angle  <= $signed(cfg_data[9:0]);
                REG_VOLTAGE_LIMIT: cfg_reg.voltage_limit <= cfg_data[6:0];
                REG_GAIN_P:        cfg_reg.gain_p        <= cfg_data;
                REG_GAIN_I:        cfg_reg.gain_i        <= cfg_data;
                REG_GAIN_D:        cfg_reg.gain_d        <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Handshake flags and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.heading <= in_ch.heading;
            item_reg.restart <= in_ch.restart;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.drive_level     = res_reg.drive_level;
    assign out_ch.finished        = res_reg.finished;
    assign out_ch.error_magnitude = res_reg.error_magnitude;

endmodule
